// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the trimmed moving average filter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- sv/tmaf_pkg.sv -----
// ----------------------------------------------------------------------------
// tmaf_pkg
// Shared types and constants of the trimmed moving average filter.
// ----------------------------------------------------------------------------
package tmaf_pkg;

  localparam int unsigned DATA_W = 16;

  // Start value of the minimum search
  localparam logic signed [DATA_W-1:0] LO_INIT = 16'sh7FFF;
  // Fill count from which the extremes are dropped
  localparam int unsigned TRIM_MIN_COUNT = 3;

  typedef struct packed {
    logic done;
    logic trim;
  } tmaf_win_stat_t;

endpackage

// ----- sv/tmaf_sample_if.sv -----
// ----------------------------------------------------------------------------
// tmaf_sample_if
// Valid/ready channel carrying one raw sample per item.
// ----------------------------------------------------------------------------
interface tmaf_sample_if;
  import tmaf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ----- sv/tmaf_filtered_if.sv -----
// ----------------------------------------------------------------------------
// tmaf_filtered_if
// Valid/ready channel carrying one filtered value per item.
// ----------------------------------------------------------------------------
interface tmaf_filtered_if;
  import tmaf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink (input valid, input filtered, output ready);
endinterface

// ----- sv/tmaf_window.sv -----
// ----------------------------------------------------------------------------
// tmaf_window
// Circular sample memory with a sequential scan that builds sum, min, max.
// ----------------------------------------------------------------------------
module tmaf_window #(
  parameter int unsigned WINDOW_LENGTH = 8,
  parameter int unsigned CNT_W         = $clog2(WINDOW_LENGTH + 1),
  parameter int unsigned SUM_W         = 18 + $clog2(WINDOW_LENGTH)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [tmaf_pkg::DATA_W-1:0] sample_i,
  output tmaf_pkg::tmaf_win_stat_t         stat_o,
  output logic signed [SUM_W-1:0]          sum_o,
  output logic [CNT_W-1:0]                 fill_o
);
  import tmaf_pkg::*;

  localparam int unsigned ADDR_W = $clog2(WINDOW_LENGTH);
  localparam int unsigned CMP_W  = CNT_W + 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WINDOW_LENGTH - 1);
  localparam logic [CNT_W-1:0]  FULL      = CNT_W'(WINDOW_LENGTH);

  typedef enum logic [2:0] {W_IDLE, W_SCAN, W_DRAIN, W_FIN, W_DONE} wstate_e;

  logic signed [DATA_W-1:0] mem [WINDOW_LENGTH];

  wstate_e                  state_q;
  logic [ADDR_W-1:0]        head_q;
  logic [ADDR_W-1:0]        rd_ptr_q;
  logic [ADDR_W-1:0]        idx_q;
  logic [CNT_W-1:0]         fill_q;
  logic                     rvalid_q;
  logic                     rzero_q;
  logic signed [DATA_W-1:0] rdata_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [DATA_W-1:0] lo_q;
  logic signed [DATA_W-1:0] hi_q;

  logic signed [DATA_W-1:0] v;
  logic                     is_zero;
  logic                     trim;

  function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] a);
    return (a == LAST_ADDR) ? '0 : a + 1'b1;
  endfunction

  // Entries never written since reset read as zero
  assign is_zero = ({{(CMP_W - ADDR_W){1'b0}}, idx_q} + {1'b0, fill_q})
                   <= CMP_W'(WINDOW_LENGTH);
  assign v       = rzero_q ? '0 : rdata_q;
  assign trim    = fill_q >= CNT_W'(TRIM_MIN_COUNT);

  always_ff @(posedge clk_i) begin
    if (state_q == W_IDLE && start_i) begin
      mem[head_q] <= sample_i;
    end
    if (state_q == W_SCAN) begin
      rdata_q <= mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= W_IDLE;
      head_q   <= '0;
      rd_ptr_q <= '0;
      idx_q    <= '0;
      fill_q   <= '0;
      rvalid_q <= 1'b0;
      rzero_q  <= 1'b0;
      sum_q    <= '0;
      lo_q     <= LO_INIT;
      hi_q     <= '0;
    end else begin
      rvalid_q <= (state_q == W_SCAN);
      rzero_q  <= is_zero;
      // accumulate the returned entry
      if (rvalid_q) begin
        sum_q <= sum_q + SUM_W'(v);
        if (v < lo_q) lo_q <= v;
        if (v > hi_q) hi_q <= v;
      end
      unique case (state_q)
        W_IDLE: begin
          if (start_i) begin
            fill_q   <= (fill_q == FULL) ? fill_q : fill_q + 1'b1;
            rd_ptr_q <= wrap_inc(head_q);
            idx_q    <= ADDR_W'(1);
            sum_q    <= SUM_W'(sample_i);
            lo_q     <= LO_INIT;
            hi_q     <= '0;
            state_q  <= W_SCAN;
          end
        end
        W_SCAN: begin
          rd_ptr_q <= wrap_inc(rd_ptr_q);
          idx_q    <= idx_q + 1'b1;
          if (idx_q == LAST_ADDR) state_q <= W_DRAIN;
        end
        W_DRAIN: state_q <= W_FIN;
        W_FIN: begin
          if (trim) sum_q <= sum_q - SUM_W'(lo_q) - SUM_W'(hi_q);
          head_q  <= wrap_inc(head_q);
          state_q <= W_DONE;
        end
        W_DONE:  state_q <= W_IDLE;
        default: state_q <= W_IDLE;
      endcase
    end
  end

  assign stat_o.done = (state_q == W_DONE);
  assign stat_o.trim = trim;
  assign sum_o       = sum_q;
  assign fill_o      = fill_q;

endmodule

// ----- sv/tmaf_divider.sv -----
// ----------------------------------------------------------------------------
// tmaf_divider
// Radix-2 restoring divider, signed dividend, truncation toward zero.
// ----------------------------------------------------------------------------
module tmaf_divider #(
  parameter int unsigned DIVIDEND_W = 21,
  parameter int unsigned DIVISOR_W  = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [DIVIDEND_W-1:0]       dividend_i,
  input  logic [DIVISOR_W-1:0]               divisor_i,
  output logic                               done_o,
  output logic signed [tmaf_pkg::DATA_W-1:0] quotient_o
);
  import tmaf_pkg::*;

  localparam int unsigned STEP_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [STEP_W-1:0]     cnt_q;
  logic                  neg_q;
  logic [DIVIDEND_W-1:0] mag_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  div_q;

  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;
  logic [DIVIDEND_W-1:0] abs_in;
  logic [DIVIDEND_W-1:0] quot_full;

  assign shifted   = {rem_q, mag_q[DIVIDEND_W-1]};
  assign diff      = shifted - {1'b0, div_q};
  assign ge        = shifted >= {1'b0, div_q};
  assign abs_in    = dividend_i[DIVIDEND_W-1] ? -dividend_i : dividend_i;
  assign quot_full = neg_q ? -mag_q : mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
      mag_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= STEP_W'(DIVIDEND_W);
        neg_q  <= dividend_i[DIVIDEND_W-1];
        mag_q  <= abs_in;
        rem_q  <= '0;
        div_q  <= divisor_i;
      end else if (busy_q) begin
        // one quotient bit per cycle
        rem_q <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        mag_q <= {mag_q[DIVIDEND_W-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quot_full[DATA_W-1:0];

endmodule

// ----- sv/trimmed_moving_average_filter_top.sv -----
// ----------------------------------------------------------------------------
// trimmed_moving_average_filter_top
// Flow: window scan, then with fewer than three samples held the raw sample is
//   passed on, else the trimmed sum is divided by the fill count minus two.
// One item at a time (no new sample until the result is loaded into the output
//   register), set by the serial scan through the single-port window memory plus the bit-serial divider.
// Reset: window reads as zero and the fill count clears; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trimmed_moving_average_filter_top #(
  parameter int unsigned WINDOW_LENGTH = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  tmaf_sample_if.sink     sample_i,
  tmaf_filtered_if.source filtered_o
);
  import tmaf_pkg::*;

  localparam int unsigned CNT_W = $clog2(WINDOW_LENGTH + 1);
  // Sum of the window minus both extremes, with headroom for the sign
  localparam int unsigned SUM_W = 18 + $clog2(WINDOW_LENGTH);

  // Sequencer: idle -> window scan -> optional divide -> hand to output reg
  typedef enum logic [1:0] {T_IDLE, T_SCAN, T_DIV, T_HOLD} state_e;

  state_e                   state_q;
  logic signed [DATA_W-1:0] sample_q;
  logic signed [DATA_W-1:0] res_q;
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] filtered_q;

  logic                     accept;
  logic                     out_free;
  tmaf_win_stat_t           win_stat;
  logic signed [SUM_W-1:0]  win_sum;
  logic [CNT_W-1:0]         win_fill;
  logic [CNT_W-1:0]         divisor;
  logic                     div_start;
  logic                     div_done;
  logic signed [DATA_W-1:0] quotient;

  assign sample_i.ready = (state_q == T_IDLE);
  assign accept         = sample_i.valid && sample_i.ready;
  // Output register may be reloaded when empty or being taken this cycle
  assign out_free       = !out_valid_q || filtered_o.ready;

  // Full window divides by N-2, partial by count-2: both are count-2
  assign divisor   = win_fill - CNT_W'(2);
  assign div_start = (state_q == T_SCAN) && win_stat.done && win_stat.trim;

  tmaf_window #(
    .WINDOW_LENGTH(WINDOW_LENGTH),
    .CNT_W        (CNT_W),
    .SUM_W        (SUM_W)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .sample_i(sample_i.sample),
    .stat_o  (win_stat),
    .sum_o   (win_sum),
    .fill_o  (win_fill)
  );

  tmaf_divider #(
    .DIVIDEND_W(SUM_W),
    .DIVISOR_W (CNT_W)
  ) u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(win_sum),
    .divisor_i (divisor),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      sample_q    <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      filtered_q  <= '0;
    end else begin
      // drop the output item once taken, unless a new one is loaded
      if (filtered_o.valid && filtered_o.ready && state_q != T_HOLD) out_valid_q <= 1'b0;
      unique case (state_q)
        T_IDLE: begin
          if (accept) begin
            sample_q <= sample_i.sample;
            state_q  <= T_SCAN;
          end
        end
        T_SCAN: begin
          if (win_stat.done) begin
            if (win_stat.trim) begin
              state_q <= T_DIV;
            end else begin
              // too few samples: pass the raw sample through
              res_q   <= sample_q;
              state_q <= T_HOLD;
            end
          end
        end
        T_DIV: begin
          if (div_done) begin
            res_q   <= quotient;
            state_q <= T_HOLD;
          end
        end
        T_HOLD: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            filtered_q  <= res_q;
            state_q     <= T_IDLE;
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  assign filtered_o.valid    = out_valid_q;
  assign filtered_o.filtered = filtered_q;

  `ASSERT_IMPLY(a_win_done_in_scan, clk_i, rst_ni, win_stat.done, state_q == T_SCAN, "window done outside scan")
  `ASSERT_IMPLY(a_div_done_in_div, clk_i, rst_ni, div_done, state_q == T_DIV, "divider done outside divide")
  `ASSERT_NEXT(a_accept_starts_scan, clk_i, rst_ni, accept, state_q == T_SCAN && !win_stat.done, "accepted item did not start a scan")

endmodule
